### rtl/core/ifs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types, constants and helpers of the chaos-game step core.
// ----------------------------------------------------------------------------
package ifs_pkg;

   localparam int DEF_MAX_MAPS      = 8;
   localparam int DEF_FRACTION_BITS = 28;
   localparam int WEIGHT_W          = 40;
   localparam int COEF_W            = 32;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic FUNC_STEP = 1'b1;

   localparam logic [0:0] CSR_MAP_COUNT   = 1'b0;
   localparam logic [0:0] CSR_COLOR_COUNT = 1'b1;

   typedef struct packed {
      logic              func;
      logic [2:0]        map_slot;
      logic [COEF_W-1:0] coef_a;
      logic [COEF_W-1:0] coef_b;
      logic [COEF_W-1:0] coef_c;
      logic [COEF_W-1:0] coef_d;
      logic [COEF_W-1:0] coef_e;
      logic [COEF_W-1:0] coef_f;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [31:0]       frac;
   } item_type;

   typedef struct packed {
      logic [3:0] map_count;
      logic [3:0] color_count;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LD_AD,
      ST_LD_BC,
      ST_LD_MAG,
      ST_LD_WT,
      ST_LD_WR,
      ST_TH_HI,
      ST_TH_LO,
      ST_TH_SUM,
      ST_SR_RD,
      ST_SR_CMP,
      ST_AF0,
      ST_AF1,
      ST_AF2,
      ST_AF3,
      ST_AF4,
      ST_AF5,
      ST_CL_START,
      ST_CL_RT,
      ST_CL_RW,
      ST_CL_RP,
      ST_CL_W,
      ST_CL_P,
      ST_CL_DEN,
      ST_CL_CH,
      ST_CL_NUM,
      ST_CL_DIV,
      ST_OUT
   } back_state_type;

   function automatic logic signed [32:0] sx33(logic [31:0] v);
      return signed'({v[31], v});
   endfunction

   function automatic logic signed [32:0] zx33(logic [31:0] v);
      return signed'({1'b0, v});
   endfunction

endpackage

### rtl/core/ifs_chaos_game_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_chaos_game_step_core
// Chaos-game step of an iterated function system, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  - request queue (req_push / req_full): a beat with func load stores one
//    affine map, its color and its cumulative weight; a beat with func step
//    moves the point by a weighted random map and gives one result beat
//  - result queue (rsp_empty / rsp_pop): oldest result is on the rsp_ ports
//    while rsp_empty is low
//  - csr port (csr_valid / csr_ready): map_count and color_count, written
//    while the core is idle; csr_ready is always high
// Sequencing:
//  - a load forms the determinant, the weight and the stores in the sequencer
//  - a step scales the fraction, searches the weights map by map, applies
//    the map and then keeps the color, sets it to white, stops at a zero
//    blend divisor or blends it channel by channel; the shared multiplier
//    and the bit-serial divider carry out this work;
//    one item is worked on at a time
//  - a two-beat queue in front lets requests land while the sequencer works
// Reset clears the point, color and weight total and both queues; map
// stores hold no valid data until loaded. A stalled result holds the
// sequencer at its last step only once the result register is full.
// ----------------------------------------------------------------------------
module ifs_chaos_game_step_core #(
   parameter int MAX_MAPS      = ifs_pkg::DEF_MAX_MAPS,
   parameter int FRACTION_BITS = ifs_pkg::DEF_FRACTION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [2:0]  req_map_slot,
   input  logic [31:0] req_coef_a,
   input  logic [31:0] req_coef_b,
   input  logic [31:0] req_coef_c,
   input  logic [31:0] req_coef_d,
   input  logic [31:0] req_coef_e,
   input  logic [31:0] req_coef_f,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [31:0] req_random_fraction,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_point_x_out,
   output logic [31:0] rsp_point_y_out,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [2:0]  rsp_chosen_map,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);

   ifs_pkg::item_type req_item;
   ifs_pkg::item_type q_item;
   ifs_pkg::cfg_type  cfg_ff;
   logic              q_valid;
   logic              q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_count   <= 4'd1;
         cfg_ff.color_count <= 4'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ifs_pkg::CSR_MAP_COUNT:   cfg_ff.map_count <= csr_data;
            ifs_pkg::CSR_COLOR_COUNT: cfg_ff.color_count <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign req_item.func     = req_func;
   assign req_item.map_slot = req_map_slot;
   assign req_item.coef_a   = req_coef_a;
   assign req_item.coef_b   = req_coef_b;
   assign req_item.coef_c   = req_coef_c;
   assign req_item.coef_d   = req_coef_d;
   assign req_item.coef_e   = req_coef_e;
   assign req_item.coef_f   = req_coef_f;
   assign req_item.red      = req_red_in;
   assign req_item.green    = req_green_in;
   assign req_item.blue     = req_blue_in;
   assign req_item.frac     = req_random_fraction;

   ifs_front #(.MAX_MAPS(MAX_MAPS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   ifs_back #(.MAX_MAPS(MAX_MAPS), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_point_x_out (rsp_point_x_out),
      .rsp_point_y_out (rsp_point_y_out),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_chosen_map  (rsp_chosen_map)
   );

`ifndef SYNTH
   a_reset_clears : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_map_in_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (32'(rsp_chosen_map) < MAX_MAPS))
      else $error("chosen map beyond the store");
`endif

endmodule

### rtl/core/ifs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ifs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ifs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_front
// Input side: takes request beats, drops loads to slots out of range and
// holds the rest in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module ifs_front #(
   parameter int MAX_MAPS = ifs_pkg::DEF_MAX_MAPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  ifs_pkg::item_type req_item,
   output logic              q_valid,
   output ifs_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam int QP_W  = (ifs_pkg::QUEUE_DEPTH > 1) ? $clog2(ifs_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ifs_pkg::QUEUE_DEPTH + 1);

   ifs_pkg::item_type ent_ff [ifs_pkg::QUEUE_DEPTH];
   logic [QP_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              keep;
   logic              enq;
   logic              deq;

   // a load to a slot past the store never reaches the sequencer
   assign keep     = (req_item.func == ifs_pkg::FUNC_STEP) ||
                     (32'(req_item.map_slot) < MAX_MAPS);
   assign req_full = (32'(cnt_ff) == ifs_pkg::QUEUE_DEPTH);
   assign enq      = req_push && !req_full && keep;
   assign q_valid  = (cnt_ff != '0);
   assign deq      = q_pop && q_valid;
   assign q_item   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq) begin
         wr_ptr_in = (32'(wr_ptr_ff) == ifs_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (32'(rd_ptr_ff) == ifs_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         ent_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

### rtl/core/ifs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifs_back
// Sequencer: stores maps and weights for loads; for steps scales the random
// fraction, searches the cumulative weights, applies the affine map on a
// shared multiplier and blends the color with a bit-serial divider.
// ----------------------------------------------------------------------------
module ifs_back #(
   parameter int MAX_MAPS      = ifs_pkg::DEF_MAX_MAPS,
   parameter int FRACTION_BITS = ifs_pkg::DEF_FRACTION_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  ifs_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  ifs_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [31:0]       rsp_point_x_out,
   output logic [31:0]       rsp_point_y_out,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_blue_out,
   output logic [2:0]        rsp_chosen_map
);

   localparam int IDX_W = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
   localparam int CNT_W = $clog2(MAX_MAPS + 1);
   localparam int W_W   = ifs_pkg::WEIGHT_W;
   localparam int P_W   = W_W + CNT_W;
   localparam int DEN_W = P_W + 1;
   localparam int NUM_W = P_W + 17;
   localparam int CF_W  = 6 * ifs_pkg::COEF_W;
   localparam logic [W_W-1:0] W_MAX = {W_W{1'b1}};
   localparam logic [W_W-1:0] EPS_W =
      W_W'(((64'd1 << FRACTION_BITS) + 64'd500) / 64'd1000);

   ifs_pkg::back_state_type state_ff, state_in;

   ifs_pkg::item_type    cur_ff;
   logic signed [32:0]   mul_a, mul_b;
   logic signed [65:0]   prod_ff;
   logic [63:0]          s1_ff;
   logic signed [64:0]   sum_ff;
   logic [64:0]          mag;
   logic [W_W-1:0]       w_ff;
   logic [W_W-1:0]       tot_ff;
   logic [W_W-1:0]       thh_ff;
   logic [W_W-1:0]       thr_ff;
   logic [IDX_W-1:0]     i_ff;
   logic [31:0]          x_ff, y_ff, nx_ff;
   logic [15:0]          col_ff [3];
   logic [W_W-1:0]       total_ff, cwi_ff, pc_ff;
   logic [P_W-1:0]       p_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [NUM_W-1:0]     na_ff, nb_ff, rem_ff;
   logic [15:0]          q_ff;
   logic [3:0]           k_ff;
   logic [1:0]           ch_ff;
   logic                 res_valid_ff;
   logic [31:0]          res_x_ff, res_y_ff;
   logic [7:0]           res_r_ff, res_g_ff, res_b_ff;
   logic [2:0]           res_map_ff;

   logic [CNT_W-1:0]     mc, cc, lim;
   logic [IDX_W-1:0]     cw_rd_addr;
   logic [W_W-1:0]       cw_q;
   logic [CF_W-1:0]      coef_q;
   logic [23:0]          color_q;
   logic                 store_wr;
   logic [IDX_W-1:0]     store_addr;
   logic [W_W-1:0]       new_tot;
   logic [W_W:0]         tot_sum;
   logic [W_W-1:0]       tot_base;
   logic                 res_load;
   logic [7:0]           mcol;
   logic [NUM_W-1:0]     trial;
   logic                 search_more;

   function automatic logic [31:0] fin(logic signed [64:0] s, logic signed [31:0] off);
      logic signed [64:0] sh;
      logic signed [65:0] r;
      sh = s >>> FRACTION_BITS;
      r  = 66'(sh) + 66'(off);
      if (r > 66'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (r < -66'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return r[31:0];
      end
   endfunction

   // effective counts
   always_comb begin
      if (cfg.map_count == '0) begin
         mc = CNT_W'(1);
      end else if (32'(cfg.map_count) > MAX_MAPS) begin
         mc = CNT_W'(MAX_MAPS);
      end else begin
         mc = CNT_W'(cfg.map_count);
      end
      if (32'(cfg.color_count) > MAX_MAPS) begin
         cc = CNT_W'(MAX_MAPS);
      end else begin
         cc = CNT_W'(cfg.color_count);
      end
      lim = (cc < mc) ? cc : mc;
   end

   assign store_addr = IDX_W'(cur_ff.map_slot);
   assign tot_base   = (cur_ff.map_slot == 3'd0) ? '0 : tot_ff;
   assign tot_sum    = {1'b0, tot_base} + {1'b0, w_ff};
   assign new_tot    = tot_sum[W_W] ? W_MAX : tot_sum[W_W-1:0];
   assign search_more = (32'(i_ff) + 1 < 32'(mc)) && (cw_q < thr_ff);
   assign trial      = NUM_W'(den_ff) << k_ff;
   assign mag        = sum_ff[64] ? 65'(-sum_ff) : 65'(sum_ff);

   always_comb begin
      case (ch_ff)
         2'd0:    mcol = color_q[23:16];
         2'd1:    mcol = color_q[15:8];
         default: mcol = color_q[7:0];
      endcase
   end

   ifs_ram #(.WIDTH(CF_W), .DEPTH(MAX_MAPS)) u_coef_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (store_addr),
      .wr_data ({cur_ff.coef_f, cur_ff.coef_e, cur_ff.coef_d,
                 cur_ff.coef_c, cur_ff.coef_b, cur_ff.coef_a}),
      .rd_addr (i_ff),
      .rd_data (coef_q)
   );

   ifs_ram #(.WIDTH(W_W), .DEPTH(MAX_MAPS)) u_cw_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (store_addr),
      .wr_data (new_tot),
      .rd_addr (cw_rd_addr),
      .rd_data (cw_q)
   );

   ifs_ram #(.WIDTH(24), .DEPTH(MAX_MAPS)) u_color_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (store_addr),
      .wr_data ({cur_ff.red, cur_ff.green, cur_ff.blue}),
      .rd_addr (i_ff),
      .rd_data (color_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ifs_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_item.func == ifs_pkg::FUNC_STEP) ?
                          ifs_pkg::ST_TH_HI : ifs_pkg::ST_LD_AD;
            end
         end
         ifs_pkg::ST_LD_AD:    state_in = ifs_pkg::ST_LD_BC;
         ifs_pkg::ST_LD_BC:    state_in = ifs_pkg::ST_LD_MAG;
         ifs_pkg::ST_LD_MAG:   state_in = ifs_pkg::ST_LD_WT;
         ifs_pkg::ST_LD_WT:    state_in = ifs_pkg::ST_LD_WR;
         ifs_pkg::ST_LD_WR:    state_in = ifs_pkg::ST_IDLE;
         ifs_pkg::ST_TH_HI:    state_in = ifs_pkg::ST_TH_LO;
         ifs_pkg::ST_TH_LO:    state_in = ifs_pkg::ST_TH_SUM;
         ifs_pkg::ST_TH_SUM:   state_in = ifs_pkg::ST_SR_RD;
         ifs_pkg::ST_SR_RD:    state_in = ifs_pkg::ST_SR_CMP;
         ifs_pkg::ST_SR_CMP:   state_in = search_more ? ifs_pkg::ST_SR_RD : ifs_pkg::ST_AF0;
         ifs_pkg::ST_AF0:      state_in = ifs_pkg::ST_AF1;
         ifs_pkg::ST_AF1:      state_in = ifs_pkg::ST_AF2;
         ifs_pkg::ST_AF2:      state_in = ifs_pkg::ST_AF3;
         ifs_pkg::ST_AF3:      state_in = ifs_pkg::ST_AF4;
         ifs_pkg::ST_AF4:      state_in = ifs_pkg::ST_AF5;
         ifs_pkg::ST_AF5:      state_in = ifs_pkg::ST_CL_START;
         ifs_pkg::ST_CL_START: begin
            if (cc == '0 || 32'(i_ff) >= 32'(cc)) begin
               state_in = ifs_pkg::ST_OUT;
            end else begin
               state_in = ifs_pkg::ST_CL_RT;
            end
         end
         ifs_pkg::ST_CL_RT:    state_in = ifs_pkg::ST_CL_RW;
         ifs_pkg::ST_CL_RW:    state_in = ifs_pkg::ST_CL_RP;
         ifs_pkg::ST_CL_RP:    state_in = ifs_pkg::ST_CL_W;
         ifs_pkg::ST_CL_W:     state_in = ifs_pkg::ST_CL_P;
         ifs_pkg::ST_CL_P:     state_in = ifs_pkg::ST_CL_DEN;
         ifs_pkg::ST_CL_DEN:   state_in = ifs_pkg::ST_CL_CH;
         ifs_pkg::ST_CL_CH: begin
            state_in = (den_ff == '0) ? ifs_pkg::ST_OUT : ifs_pkg::ST_CL_NUM;
         end
         ifs_pkg::ST_CL_NUM:   state_in = ifs_pkg::ST_CL_DIV;
         ifs_pkg::ST_CL_DIV: begin
            if (k_ff == '0) begin
               state_in = (ch_ff == 2'd2) ? ifs_pkg::ST_OUT : ifs_pkg::ST_CL_CH;
            end
         end
         ifs_pkg::ST_OUT: begin
            if (!res_valid_ff || rsp_pop) begin
               state_in = ifs_pkg::ST_IDLE;
            end
         end
         default:              state_in = ifs_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop      = 1'b0;
      store_wr   = 1'b0;
      res_load   = 1'b0;
      cw_rd_addr = i_ff;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         ifs_pkg::ST_IDLE:   q_pop = q_valid;
         ifs_pkg::ST_LD_AD: begin
            mul_a = ifs_pkg::sx33(cur_ff.coef_a);
            mul_b = ifs_pkg::sx33(cur_ff.coef_d);
         end
         ifs_pkg::ST_LD_BC: begin
            mul_a = ifs_pkg::sx33(cur_ff.coef_b);
            mul_b = ifs_pkg::sx33(cur_ff.coef_c);
         end
         ifs_pkg::ST_LD_WR:  store_wr = 1'b1;
         ifs_pkg::ST_TH_HI: begin
            mul_a = ifs_pkg::zx33(cur_ff.frac);
            mul_b = ifs_pkg::zx33(32'(tot_ff[W_W-1:32]));
         end
         ifs_pkg::ST_TH_LO: begin
            mul_a = ifs_pkg::zx33(cur_ff.frac);
            mul_b = ifs_pkg::zx33(tot_ff[31:0]);
         end
         ifs_pkg::ST_AF0: begin
            mul_a = ifs_pkg::sx33(coef_q[31:0]);
            mul_b = ifs_pkg::sx33(x_ff);
         end
         ifs_pkg::ST_AF1: begin
            mul_a = ifs_pkg::sx33(coef_q[63:32]);
            mul_b = ifs_pkg::sx33(y_ff);
         end
         ifs_pkg::ST_AF2: begin
            mul_a = ifs_pkg::sx33(coef_q[95:64]);
            mul_b = ifs_pkg::sx33(x_ff);
         end
         ifs_pkg::ST_AF3: begin
            mul_a = ifs_pkg::sx33(coef_q[127:96]);
            mul_b = ifs_pkg::sx33(y_ff);
         end
         ifs_pkg::ST_CL_RT:  cw_rd_addr = IDX_W'(lim - CNT_W'(1));
         ifs_pkg::ST_CL_RP:  cw_rd_addr = i_ff - 1'b1;
         ifs_pkg::ST_OUT:    res_load = !res_valid_ff || rsp_pop;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         tot_ff    <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         col_ff[0] <= '0;
         col_ff[1] <= '0;
         col_ff[2] <= '0;
      end else begin
         if (state_ff == ifs_pkg::ST_LD_WR) begin
            tot_ff <= new_tot;
         end
         if (state_ff == ifs_pkg::ST_AF5) begin
            x_ff <= nx_ff;
            y_ff <= fin(sum_ff, signed'(coef_q[191:160]));
         end
         if (state_ff == ifs_pkg::ST_CL_START && cc == '0) begin
            col_ff[0] <= 16'hFFFF;
            col_ff[1] <= 16'hFFFF;
            col_ff[2] <= 16'hFFFF;
         end
         if (state_ff == ifs_pkg::ST_CL_DIV && k_ff == '0 && ch_ff != 2'd3) begin
            col_ff[ch_ff] <= (rem_ff >= trial) ? (q_ff | 16'd1) : q_ff;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         ifs_pkg::ST_IDLE:   cur_ff <= q_item;
         ifs_pkg::ST_LD_BC:  s1_ff <= prod_ff[63:0];
         ifs_pkg::ST_LD_MAG: begin
            sum_ff <= signed'({s1_ff[63], s1_ff}) - signed'(prod_ff[64:0]);
         end
         ifs_pkg::ST_LD_WR: begin
         end
         ifs_pkg::ST_TH_LO:  thh_ff <= prod_ff[W_W-1:0];
         ifs_pkg::ST_TH_SUM: begin
            thr_ff <= thh_ff + W_W'(prod_ff[63:32]);
            i_ff   <= '0;
         end
         ifs_pkg::ST_SR_CMP: begin
            if (search_more) begin
               i_ff <= i_ff + 1'b1;
            end
         end
         ifs_pkg::ST_AF1:    s1_ff <= prod_ff[63:0];
         ifs_pkg::ST_AF2:    sum_ff <= signed'({s1_ff[63], s1_ff}) + signed'(prod_ff[64:0]);
         ifs_pkg::ST_AF3: begin
            nx_ff <= fin(sum_ff, signed'(coef_q[159:128]));
            s1_ff <= prod_ff[63:0];
         end
         ifs_pkg::ST_AF4:    sum_ff <= signed'({s1_ff[63], s1_ff}) + signed'(prod_ff[64:0]);
         ifs_pkg::ST_CL_RW:  total_ff <= cw_q;
         ifs_pkg::ST_CL_RP:  cwi_ff <= cw_q;
         ifs_pkg::ST_CL_W: begin
            // cw_q holds the previous map's cumulative weight here
            if (i_ff == '0) begin
               w_ff <= cwi_ff;
            end else begin
               w_ff <= (cwi_ff > cw_q) ? cwi_ff - cw_q : '0;
            end
         end
         ifs_pkg::ST_CL_P: begin
            pc_ff <= (total_ff > w_ff) ? total_ff - w_ff : '0;
            p_ff  <= P_W'(w_ff) * P_W'(lim - CNT_W'(1));
         end
         ifs_pkg::ST_CL_DEN: begin
            den_ff <= DEN_W'(p_ff) + DEN_W'(pc_ff);
            ch_ff  <= '0;
         end
         ifs_pkg::ST_CL_CH: begin
            na_ff <= NUM_W'(col_ff[ch_ff]) * NUM_W'(p_ff);
            nb_ff <= NUM_W'({mcol, mcol}) * NUM_W'(pc_ff);
         end
         ifs_pkg::ST_CL_NUM: begin
            rem_ff <= na_ff + nb_ff;
            q_ff   <= '0;
            k_ff   <= 4'd15;
         end
         ifs_pkg::ST_CL_DIV: begin
            // restoring division, one quotient bit a cycle
            if (rem_ff >= trial) begin
               rem_ff   <= rem_ff - trial;
               q_ff[k_ff] <= 1'b1;
            end
            if (k_ff == '0) begin
               ch_ff <= ch_ff + 1'b1;
            end else begin
               k_ff <= k_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (state_ff == ifs_pkg::ST_LD_WT) begin
         if ((mag >> FRACTION_BITS) + 65'(EPS_W) > 65'(W_MAX)) begin
            w_ff <= W_MAX;
         end else begin
            w_ff <= W_W'((mag >> FRACTION_BITS) + 65'(EPS_W));
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (res_load) begin
         res_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_x_ff   <= x_ff;
         res_y_ff   <= y_ff;
         res_r_ff   <= col_ff[0][15:8];
         res_g_ff   <= col_ff[1][15:8];
         res_b_ff   <= col_ff[2][15:8];
         res_map_ff <= 3'(i_ff);
      end
   end

   assign rsp_empty       = !res_valid_ff;
   assign rsp_point_x_out = res_x_ff;
   assign rsp_point_y_out = res_y_ff;
   assign rsp_red_out     = res_r_ff;
   assign rsp_green_out   = res_g_ff;
   assign rsp_blue_out    = res_b_ff;
   assign rsp_chosen_map  = res_map_ff;

endmodule
